// ----- rtl/core/sipsu_pkg.sv -----
// Types and constants of the sphere impostor pixel shade unit.
// Used by the top level; no dependencies.
package sipsu_pkg;

  // Configuration port geometry (64-bit registers at 8-byte strides)
  localparam int CFG_AW = 6;

  // Register indexes
  typedef enum logic [2:0] {
    REG_SUN_X       = 3'd0,
    REG_SUN_Y       = 3'd1,
    REG_SUN_Z       = 3'd2,
    REG_NEAR_PLANE  = 3'd3,
    REG_DEPTH_SCALE = 3'd4
  } reg_idx_t;

  // Register reset values
  localparam logic signed [15:0] SUN_X_RST       = 16'sd0;
  localparam logic signed [15:0] SUN_Y_RST       = 16'sd0;
  localparam logic signed [15:0] SUN_Z_RST       = -16'sd16384;
  localparam logic [23:0]        NEAR_PLANE_RST  = 24'd410;
  localparam logic [39:0]        DEPTH_SCALE_RST = 40'h0010000000;

  // Shading and geometry constants
  localparam logic [16:0] AMBIENT_Q14 = 17'd3604;   // 0.22 in Q.14
  localparam logic [13:0] DIFFUSE_Q14 = 14'd12780;  // 0.78 in Q.14
  localparam logic [15:0] MIN_RADIUS  = 16'd8;      // half a pixel in Q.4
  localparam logic [28:0] ONE_Q28     = 29'h1000_0000;
  localparam logic [4:0]  RB_MAX      = 5'h1F;
  localparam logic [5:0]  G_MAX       = 6'h3F;
  localparam logic [15:0] DEPTH_MAX   = 16'hFFFF;

  // Iteration counts of the pipelined units
  localparam int NDIV_STEPS = 15;  // quotient bits of the normal divide
  localparam int SQRT_STEPS = 15;  // root bits of nz
  localparam int DDIV_STEPS = 16;  // quotient bits of the depth divide

  typedef struct packed {
    logic [9:0]         pixel_x;
    logic [9:0]         pixel_y;
    logic signed [15:0] center_x;
    logic signed [15:0] center_y;
    logic [15:0]        radius_px;
    logic [23:0]        view_depth;
    logic [23:0]        world_radius;
    logic [15:0]        base_color;
    logic [15:0]        stored_depth;
  } in_item_t;

  typedef struct packed {
    logic        write_enable;
    logic [15:0] new_depth;
    logic [15:0] new_color;
  } out_item_t;

  // Fragment context carried through the front of the pipe
  typedef struct packed {
    logic        cov;
    logic [15:0] r;
    logic [23:0] vz;
    logic [23:0] wr;
    logic [15:0] col;
    logic [15:0] stored;
  } frag_t;

  // Normal divide state: |d| * 2^14 / r for x and y
  typedef struct packed {
    logic        neg_x;
    logic        neg_y;
    logic [15:0] rem_x;
    logic [15:0] rem_y;
    logic [14:0] lo_x;
    logic [14:0] lo_y;
    logic [14:0] q_x;
    logic [14:0] q_y;
  } ndiv_t;

  // Square root state
  typedef struct packed {
    logic [16:0] rem;
    logic [14:0] root;
    logic [29:0] v;
  } sqrt_t;

  // Sideband next to the square root
  typedef struct packed {
    frag_t              f;
    logic signed [15:0] ndx;
    logic signed [15:0] ndy;
  } side_t;

  // Depth divide state
  typedef struct packed {
    logic        sat;
    logic [23:0] rem;
    logic [15:0] lo;
    logic [15:0] q;
    logic [23:0] zf;
  } ddiv_t;

  // Tail context after lighting
  typedef struct packed {
    logic        cov;
    logic [15:0] col;
    logic [15:0] stored;
  } tail_t;

  // One restoring step of both normal divides
  function automatic ndiv_t ndiv_step(ndiv_t s, logic [15:0] r);
    logic [16:0] tx;
    logic [16:0] ty;
    ndiv_t       o;
    o  = s;
    tx = {s.rem_x, s.lo_x[14]};
    ty = {s.rem_y, s.lo_y[14]};
    if (tx >= {1'b0, r}) begin
      o.rem_x = 16'(tx - {1'b0, r});
      o.q_x   = {s.q_x[13:0], 1'b1};
    end else begin
      o.rem_x = tx[15:0];
      o.q_x   = {s.q_x[13:0], 1'b0};
    end
    if (ty >= {1'b0, r}) begin
      o.rem_y = 16'(ty - {1'b0, r});
      o.q_y   = {s.q_y[13:0], 1'b1};
    end else begin
      o.rem_y = ty[15:0];
      o.q_y   = {s.q_y[13:0], 1'b0};
    end
    o.lo_x = {s.lo_x[13:0], 1'b0};
    o.lo_y = {s.lo_y[13:0], 1'b0};
    return o;
  endfunction

  // One digit of the bit-pair square root
  function automatic sqrt_t sqrt_step(sqrt_t s);
    logic [18:0] rm;
    logic [18:0] t;
    sqrt_t       o;
    rm = {s.rem, s.v[29:28]};
    t  = {2'b00, s.root, 2'b01};
    if (rm >= t) begin
      o.rem  = 17'(rm - t);
      o.root = {s.root[13:0], 1'b1};
    end else begin
      o.rem  = rm[16:0];
      o.root = {s.root[13:0], 1'b0};
    end
    o.v = {s.v[27:0], 2'b00};
    return o;
  endfunction

  // One restoring step of the depth divide
  function automatic ddiv_t ddiv_step(ddiv_t s);
    logic [24:0] t;
    ddiv_t       o;
    o = s;
    t = {s.rem, s.lo[15]};
    if (t >= {1'b0, s.zf}) begin
      o.rem = 24'(t - {1'b0, s.zf});
      o.q   = {s.q[14:0], 1'b1};
    end else begin
      o.rem = t[23:0];
      o.q   = {s.q[14:0], 1'b0};
    end
    o.lo = {s.lo[14:0], 1'b0};
    return o;
  endfunction

endpackage

// ----- rtl/core/sipsu_in_if.sv -----
// Fragment request channel of the sphere impostor pixel shade unit.
// Valid/ready handshake; no dependencies.
interface sipsu_in_if;
  logic               valid;
  logic               ready;
  logic [9:0]         pixel_x;
  logic [9:0]         pixel_y;
  logic signed [15:0] center_x;
  logic signed [15:0] center_y;
  logic [15:0]        radius_px;
  logic [23:0]        view_depth;
  logic [23:0]        world_radius;
  logic [15:0]        base_color;
  logic [15:0]        stored_depth;

  modport source (
    output valid, pixel_x, pixel_y, center_x, center_y, radius_px,
           view_depth, world_radius, base_color, stored_depth,
    input  ready
  );
  modport sink (
    input  valid, pixel_x, pixel_y, center_x, center_y, radius_px,
           view_depth, world_radius, base_color, stored_depth,
    output ready
  );
endinterface

// ----- rtl/core/sipsu_out_if.sv -----
// Result request channel of the sphere impostor pixel shade unit.
// Valid/ready handshake; no dependencies.
interface sipsu_out_if;
  logic        valid;
  logic        ready;
  logic        write_enable;
  logic [15:0] new_depth;
  logic [15:0] new_color;

  modport source (
    output valid, write_enable, new_depth, new_color,
    input  ready
  );
  modport sink (
    input  valid, write_enable, new_depth, new_color,
    output ready
  );
endinterface

// ----- rtl/core/sphere_impostor_pixel_shade_unit.sv -----
// Top level of the sphere impostor pixel shade unit: coverage, normal,
// lighting and reciprocal depth in one stall-controlled pipeline.
// Depends on sipsu_pkg, sipsu_in_if and sipsu_out_if.
//
//   port      | dir | protocol    | moves
//   ----------+-----+-------------+----------------------------------------
//   in_chan   | in  | valid/ready | one fragment request per accept
//   out_chan  | out | valid/ready | one write decision per fragment
//   psel..    | in  | APB         | register writes/reads, 64-bit at 8*i
//
// One request enters per clock while the skid entry is empty; results leave
// in order. Most of the pipe's length comes from the 15-step normal divide,
// the 15-step square root and the 16-step depth divide.
// Reset (rst_n low, synchronous) clears all valid bits and loads the
// register defaults. A stalled output fills a one-entry skid buffer, which
// then freezes the whole pipe and drops in_chan.ready while it is occupied.
module sphere_impostor_pixel_shade_unit #(
  parameter int SCREEN_WIDTH  = 1024,
  parameter int SCREEN_HEIGHT = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  sipsu_in_if.sink                      in_chan,
  sipsu_out_if.source                   out_chan,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [sipsu_pkg::CFG_AW-1:0]  paddr,
  input  logic [63:0]                   pwdata,
  output logic [63:0]                   prdata,
  output logic                          pready
);
  import sipsu_pkg::*;

  localparam logic [12:0] SCR_W = 13'(SCREEN_WIDTH);
  localparam logic [12:0] SCR_H = 13'(SCREEN_HEIGHT);

  // ---------------------------------------------------------------------
  // Configuration registers
  logic signed [15:0] sun_x_r, sun_y_r, sun_z_r;
  logic [23:0]        near_r;
  logic [39:0]        scale_r;
  reg_idx_t           cfg_idx;

  assign cfg_idx = reg_idx_t'(paddr[CFG_AW-1:3]);
  assign pready  = 1'b1;

  // Write a register on the access phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sun_x_r <= SUN_X_RST;
      sun_y_r <= SUN_Y_RST;
      sun_z_r <= SUN_Z_RST;
      near_r  <= NEAR_PLANE_RST;
      scale_r <= DEPTH_SCALE_RST;
    end else if (psel && penable && pwrite) begin
      case (cfg_idx)
        REG_SUN_X:       sun_x_r <= pwdata[15:0];
        REG_SUN_Y:       sun_y_r <= pwdata[15:0];
        REG_SUN_Z:       sun_z_r <= pwdata[15:0];
        REG_NEAR_PLANE:  near_r  <= pwdata[23:0];
        REG_DEPTH_SCALE: scale_r <= pwdata[39:0];
        default: ;
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    case (cfg_idx)
      REG_SUN_X:       prdata = 64'(sun_x_r);
      REG_SUN_Y:       prdata = 64'(sun_y_r);
      REG_SUN_Z:       prdata = 64'(sun_z_r);
      REG_NEAR_PLANE:  prdata = {40'd0, near_r};
      REG_DEPTH_SCALE: prdata = {24'd0, scale_r};
      default:         prdata = 64'd0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Pipe enable: the whole pipe holds while the skid entry is occupied
  logic skid_v_r;
  logic en;

  assign en            = !skid_v_r;
  assign in_chan.ready = en;

  // ---------------------------------------------------------------------
  // Stage A: capture the request
  logic     a_v_r;
  in_item_t a_r;
  in_item_t a_nxt;

  always_comb begin
    a_nxt.pixel_x      = in_chan.pixel_x;
    a_nxt.pixel_y      = in_chan.pixel_y;
    a_nxt.center_x     = in_chan.center_x;
    a_nxt.center_y     = in_chan.center_y;
    a_nxt.radius_px    = in_chan.radius_px;
    a_nxt.view_depth   = in_chan.view_depth;
    a_nxt.world_radius = in_chan.world_radius;
    a_nxt.base_color   = in_chan.base_color;
    a_nxt.stored_depth = in_chan.stored_depth;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) a_v_r <= 1'b0;
    else if (en) a_v_r <= in_chan.valid;
  end
  always_ff @(posedge clk) begin
    if (en) a_r <= a_nxt;
  end

  // ---------------------------------------------------------------------
  // Stage B: offsets from the pixel centre, coarse rejects
  logic               b_v_r;
  logic signed [17:0] b_dx_r, b_dy_r, b_dx_nxt, b_dy_nxt;
  frag_t              b_f_r, b_f_nxt;

  always_comb begin
    b_dx_nxt = $signed({4'b0000, a_r.pixel_x, 4'b1000})
             - $signed({{2{a_r.center_x[15]}}, a_r.center_x});
    b_dy_nxt = $signed({4'b0000, a_r.pixel_y, 4'b1000})
             - $signed({{2{a_r.center_y[15]}}, a_r.center_y});
    b_f_nxt.cov    = (a_r.radius_px >= MIN_RADIUS)
                  && ({3'b000, a_r.pixel_x} < SCR_W)
                  && ({3'b000, a_r.pixel_y} < SCR_H);
    b_f_nxt.r      = a_r.radius_px;
    b_f_nxt.vz     = a_r.view_depth;
    b_f_nxt.wr     = a_r.world_radius;
    b_f_nxt.col    = a_r.base_color;
    b_f_nxt.stored = a_r.stored_depth;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) b_v_r <= 1'b0;
    else if (en) b_v_r <= a_v_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      b_dx_r <= b_dx_nxt;
      b_dy_r <= b_dy_nxt;
      b_f_r  <= b_f_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Stage C: squares for the disc test, magnitudes for the divide
  logic               c_v_r;
  logic [31:0]        c_sqx_r, c_sqy_r, c_rr_r;
  logic [16:0]        c_adx_r, c_ady_r;
  logic               c_negx_r, c_negy_r;
  frag_t              c_f_r;
  logic signed [35:0] c_sqx_full, c_sqy_full;
  logic [16:0]        c_adx_nxt, c_ady_nxt;

  always_comb begin
    c_sqx_full = b_dx_r * b_dx_r;
    c_sqy_full = b_dy_r * b_dy_r;
    c_adx_nxt  = b_dx_r[17] ? 17'(-b_dx_r) : b_dx_r[16:0];
    c_ady_nxt  = b_dy_r[17] ? 17'(-b_dy_r) : b_dy_r[16:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) c_v_r <= 1'b0;
    else if (en) c_v_r <= b_v_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      c_sqx_r  <= c_sqx_full[31:0];
      c_sqy_r  <= c_sqy_full[31:0];
      c_rr_r   <= 32'(b_f_r.r) * 32'(b_f_r.r);
      c_adx_r  <= c_adx_nxt;
      c_ady_r  <= c_ady_nxt;
      c_negx_r <= b_dx_r[17];
      c_negy_r <= b_dy_r[17];
      c_f_r    <= b_f_r;
    end
  end

  // ---------------------------------------------------------------------
  // Stage D: disc test and normal divide setup
  logic  ndv_v_r [NDIV_STEPS+1];
  ndiv_t ndv_r   [NDIV_STEPS+1];
  frag_t ndf_r   [NDIV_STEPS+1];
  ndiv_t d_nxt;
  frag_t d_f_nxt;

  always_comb begin
    d_f_nxt     = c_f_r;
    d_f_nxt.cov = c_f_r.cov
               && (({1'b0, c_sqx_r} + {1'b0, c_sqy_r}) <= {1'b0, c_rr_r});
    // |d| * 2^14: the top 16 bits sit below r whenever the pixel is covered
    d_nxt.neg_x = c_negx_r;
    d_nxt.neg_y = c_negy_r;
    d_nxt.rem_x = c_adx_r[16:1];
    d_nxt.rem_y = c_ady_r[16:1];
    d_nxt.lo_x  = {c_adx_r[0], 14'd0};
    d_nxt.lo_y  = {c_ady_r[0], 14'd0};
    d_nxt.q_x   = '0;
    d_nxt.q_y   = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) ndv_v_r[0] <= 1'b0;
    else if (en) ndv_v_r[0] <= c_v_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      ndv_r[0] <= d_nxt;
      ndf_r[0] <= d_f_nxt;
    end
  end

  // Normal divide: one quotient bit per stage
  for (genvar k = 0; k < NDIV_STEPS; k++) begin : g_ndiv
    always_ff @(posedge clk) begin
      if (!rst_n) ndv_v_r[k+1] <= 1'b0;
      else if (en) ndv_v_r[k+1] <= ndv_v_r[k];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        ndv_r[k+1] <= ndiv_step(ndv_r[k], ndf_r[k].r);
        ndf_r[k+1] <= ndf_r[k];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stage E: signed normal components and their squares
  logic        e_v_r;
  logic [28:0] e_qx2_r, e_qy2_r;
  side_t       e_s_r, e_s_nxt;
  ndiv_t       nd_last;

  always_comb begin
    nd_last   = ndv_r[NDIV_STEPS];
    e_s_nxt.f = ndf_r[NDIV_STEPS];
    e_s_nxt.ndx = nd_last.neg_x ? -$signed({1'b0, nd_last.q_x})
                                : $signed({1'b0, nd_last.q_x});
    e_s_nxt.ndy = nd_last.neg_y ? -$signed({1'b0, nd_last.q_y})
                                : $signed({1'b0, nd_last.q_y});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) e_v_r <= 1'b0;
    else if (en) e_v_r <= ndv_v_r[NDIV_STEPS];
  end
  always_ff @(posedge clk) begin
    if (en) begin
      e_qx2_r <= 29'(nd_last.q_x) * 29'(nd_last.q_x);
      e_qy2_r <= 29'(nd_last.q_y) * 29'(nd_last.q_y);
      e_s_r   <= e_s_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Stage F: 1 - ndx^2 - ndy^2, clamped at zero, into the square root
  logic  sqv_v_r [SQRT_STEPS+1];
  sqrt_t sqv_r   [SQRT_STEPS+1];
  side_t sqs_r   [SQRT_STEPS+1];
  logic [29:0] f_sum;
  sqrt_t       f_nxt;

  always_comb begin
    f_sum      = {1'b0, e_qx2_r} + {1'b0, e_qy2_r};
    f_nxt.rem  = '0;
    f_nxt.root = '0;
    f_nxt.v    = (f_sum > {1'b0, ONE_Q28}) ? 30'd0 : 30'({1'b0, ONE_Q28} - f_sum);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) sqv_v_r[0] <= 1'b0;
    else if (en) sqv_v_r[0] <= e_v_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      sqv_r[0] <= f_nxt;
      sqs_r[0] <= e_s_r;
    end
  end

  // Square root: one root bit per stage
  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    always_ff @(posedge clk) begin
      if (!rst_n) sqv_v_r[k+1] <= 1'b0;
      else if (en) sqv_v_r[k+1] <= sqv_v_r[k];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        sqv_r[k+1] <= sqrt_step(sqv_r[k]);
        sqs_r[k+1] <= sqs_r[k];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stage G: sun products and the depth offset product
  logic               g_v_r;
  logic signed [31:0] g_px_r, g_py_r, g_pz_r;
  logic [38:0]        g_wz_r;
  frag_t              g_f_r;
  side_t              sq_side;
  logic signed [15:0] nz_s;

  always_comb begin
    sq_side = sqs_r[SQRT_STEPS];
    nz_s    = $signed({1'b0, sqv_r[SQRT_STEPS].root});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) g_v_r <= 1'b0;
    else if (en) g_v_r <= sqv_v_r[SQRT_STEPS];
  end
  always_ff @(posedge clk) begin
    if (en) begin
      g_px_r <= sq_side.ndx * sun_x_r;
      g_py_r <= sq_side.ndy * sun_y_r;
      g_pz_r <= nz_s * sun_z_r;
      g_wz_r <= 39'(sq_side.f.wr) * 39'(sqv_r[SQRT_STEPS].root);
      g_f_r  <= sq_side.f;
    end
  end

  // ---------------------------------------------------------------------
  // Stage H: sun term px - py - pz, surface depth clamped at the near plane
  logic               h_v_r, h_pos_r;
  logic [16:0]        h_dh_r;
  logic [23:0]        h_zf_r, h_zf_nxt;
  tail_t              h_t_r, h_t_nxt;
  logic signed [33:0] h_dot;
  logic signed [25:0] h_zf;

  always_comb begin
    h_dot    = 34'(g_px_r) - 34'(g_py_r) - 34'(g_pz_r);
    h_zf     = $signed({2'b00, g_f_r.vz}) - $signed({1'b0, g_wz_r[38:14]});
    h_zf_nxt = (h_zf < $signed({2'b00, near_r})) ? near_r : h_zf[23:0];
    h_t_nxt.cov    = g_f_r.cov;
    h_t_nxt.col    = g_f_r.col;
    h_t_nxt.stored = g_f_r.stored;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) h_v_r <= 1'b0;
    else if (en) h_v_r <= g_v_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      h_pos_r <= !h_dot[33] && (h_dot != '0);
      h_dh_r  <= h_dot[30:14];
      h_zf_r  <= h_zf_nxt;
      h_t_r   <= h_t_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Stage I: diffuse weight times the sun term
  logic        i_v_r, i_pos_r;
  logic [30:0] i_m_r;
  logic [23:0] i_zf_r;
  tail_t       i_t_r;

  always_ff @(posedge clk) begin
    if (!rst_n) i_v_r <= 1'b0;
    else if (en) i_v_r <= h_v_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      i_pos_r <= h_pos_r;
      i_m_r   <= 31'(DIFFUSE_Q14) * 31'(h_dh_r);
      i_zf_r  <= h_zf_r;
      i_t_r   <= h_t_r;
    end
  end

  // ---------------------------------------------------------------------
  // Stage J: shade factor, ambient plus lit diffuse
  logic        j_v_r;
  logic [16:0] j_sh_r;
  logic [23:0] j_zf_r;
  tail_t       j_t_r;

  always_ff @(posedge clk) begin
    if (!rst_n) j_v_r <= 1'b0;
    else if (en) j_v_r <= i_v_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      j_sh_r <= i_pos_r ? 17'(AMBIENT_Q14 + 17'(i_m_r[30:14])) : AMBIENT_Q14;
      j_zf_r <= i_zf_r;
      j_t_r  <= i_t_r;
    end
  end

  // ---------------------------------------------------------------------
  // Stage K: scale each color channel
  logic        k_v_r;
  logic [21:0] k_pr_r, k_pb_r;
  logic [22:0] k_pg_r;
  logic [23:0] k_zf_r;
  tail_t       k_t_r;

  always_ff @(posedge clk) begin
    if (!rst_n) k_v_r <= 1'b0;
    else if (en) k_v_r <= j_v_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      k_pr_r <= 22'(j_t_r.col[15:11]) * 22'(j_sh_r);
      k_pg_r <= 23'(j_t_r.col[10:5]) * 23'(j_sh_r);
      k_pb_r <= 22'(j_t_r.col[4:0]) * 22'(j_sh_r);
      k_zf_r <= j_zf_r;
      k_t_r  <= j_t_r;
    end
  end

  // ---------------------------------------------------------------------
  // Stage L: saturate channels and repack RGB565
  logic        l_v_r;
  logic [23:0] l_zf_r;
  tail_t       l_t_r, l_t_nxt;
  logic [4:0]  l_rc, l_bc;
  logic [5:0]  l_gc;

  always_comb begin
    l_rc = (k_pr_r[21:14] > 8'(RB_MAX)) ? RB_MAX : k_pr_r[18:14];
    l_gc = (k_pg_r[22:14] > 9'(G_MAX))  ? G_MAX  : k_pg_r[19:14];
    l_bc = (k_pb_r[21:14] > 8'(RB_MAX)) ? RB_MAX : k_pb_r[18:14];
    l_t_nxt     = k_t_r;
    l_t_nxt.col = {l_rc, l_gc, l_bc};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) l_v_r <= 1'b0;
    else if (en) l_v_r <= k_v_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      l_zf_r <= k_zf_r;
      l_t_r  <= l_t_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Stage M: depth divide setup; saturate when the quotient tops 16 bits
  logic  ddv_v_r [DDIV_STEPS+1];
  ddiv_t ddv_r   [DDIV_STEPS+1];
  tail_t ddt_r   [DDIV_STEPS+1];
  ddiv_t m_nxt;

  always_comb begin
    m_nxt.sat = (l_zf_r == '0) || (scale_r[39:16] >= l_zf_r);
    m_nxt.rem = scale_r[39:16];
    m_nxt.lo  = scale_r[15:0];
    m_nxt.q   = '0;
    m_nxt.zf  = l_zf_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) ddv_v_r[0] <= 1'b0;
    else if (en) ddv_v_r[0] <= l_v_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      ddv_r[0] <= m_nxt;
      ddt_r[0] <= l_t_r;
    end
  end

  // Depth divide: one quotient bit per stage
  for (genvar k = 0; k < DDIV_STEPS; k++) begin : g_ddiv
    always_ff @(posedge clk) begin
      if (!rst_n) ddv_v_r[k+1] <= 1'b0;
      else if (en) ddv_v_r[k+1] <= ddv_v_r[k];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        ddv_r[k+1] <= ddiv_step(ddv_r[k]);
        ddt_r[k+1] <= ddt_r[k];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Final stage: depth test and result
  logic      fin_v_r;
  out_item_t fin_r, fin_nxt;
  logic [15:0] fin_d;
  logic        fin_we;

  always_comb begin
    fin_d  = ddv_r[DDIV_STEPS].sat ? DEPTH_MAX : ddv_r[DDIV_STEPS].q;
    fin_we = ddt_r[DDIV_STEPS].cov && (fin_d > ddt_r[DDIV_STEPS].stored);
    fin_nxt.write_enable = fin_we;
    fin_nxt.new_depth    = fin_we ? fin_d : 16'd0;
    fin_nxt.new_color    = fin_we ? ddt_r[DDIV_STEPS].col : 16'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) fin_v_r <= 1'b0;
    else if (en) fin_v_r <= ddv_v_r[DDIV_STEPS];
  end
  always_ff @(posedge clk) begin
    if (en) fin_r <= fin_nxt;
  end

  // ---------------------------------------------------------------------
  // Output register with one skid entry
  logic      out_v_r;
  out_item_t out_r, skid_r;
  logic      take, pop;

  assign take = out_v_r && out_chan.ready;
  assign pop  = en && fin_v_r;

  // Advance the output and skid valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (take || !out_v_r) begin
        out_v_r  <= 1'b1;
        skid_v_r <= 1'b0;
      end
    end else if (pop) begin
      if (!out_v_r || take) out_v_r <= 1'b1;
      else skid_v_r <= 1'b1;
    end else if (take) begin
      out_v_r <= 1'b0;
    end
  end

  // Move payloads alongside
  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (take || !out_v_r) out_r <= skid_r;
    end else if (pop) begin
      if (!out_v_r || take) out_r <= fin_r;
      else skid_r <= fin_r;
    end
  end

  assign out_chan.valid        = out_v_r;
  assign out_chan.write_enable = out_r.write_enable;
  assign out_chan.new_depth    = out_r.new_depth;
  assign out_chan.new_color    = out_r.new_color;

endmodule
